// ----- hw/rtl/sne_pkg.sv -----
// Shared types, constants and the direction quantiser for the Sobel/NMS edge classifier.
// No dependencies; every other file imports this package.
package sne_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;
  localparam int unsigned MIN_SIZE       = 3;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned GRAD_W     = 11;
  localparam int unsigned MAG_W      = 11;
  localparam int unsigned THR_W      = 11;
  localparam int unsigned WCFG_W     = 11;
  localparam int unsigned HCFG_W     = 13;
  localparam int unsigned CLASS_W    = 2;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DEPTH  = 8;

  localparam int unsigned HIGH_RESET   = 180;
  localparam int unsigned LOW_RESET    = 70;
  localparam int unsigned WIDTH_RESET  = 1024;
  localparam int unsigned HEIGHT_RESET = 1024;

  // tan 22.5 and tan 67.5 scaled by TAN_DEN
  localparam int unsigned TAN_DEN   = 10000;
  localparam int unsigned TAN22_NUM = 4142;
  localparam int unsigned TAN67_NUM = 24142;
  localparam int unsigned PROD_W    = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_THR = 2'd0,
    CFG_LOW_THR  = 2'd1,
    CFG_WIDTH    = 2'd2,
    CFG_HEIGHT   = 2'd3
  } cfg_reg_e;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_BG     = 2'd0,
    CLASS_WEAK   = 2'd1,
    CLASS_STRONG = 2'd2
  } edge_class_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_HORZ    = 2'd0,
    DIR_DIAG_DR = 2'd1,
    DIR_VERT    = 2'd2,
    DIR_DIAG_DL = 2'd3
  } dir_e;

  // position flags that travel with an item down the pipeline
  typedef struct packed {
    logic grad_en;    // gradient position is inside the frame
    logic grad_int;   // gradient position is interior
    logic cls_en;     // result describes a real pixel
    logic cls_int;    // result position is interior
    logic frame_end;  // result is the frame's last pixel
  } pos_flags_t;

  typedef struct packed {
    logic               out_valid;
    logic [CLASS_W-1:0] edge_class;
    logic [DIR_W-1:0]   direction;
    logic [MAG_W-1:0]   magnitude;
    logic               frame_end;
  } result_t;

  function automatic dir_e quantize(input logic signed [GRAD_W-1:0] dx,
                                    input logic signed [GRAD_W-1:0] dy);
    logic [GRAD_W-1:0] ax;
    logic [GRAD_W-1:0] ay;
    logic [PROD_W-1:0] ty;
    logic [PROD_W-1:0] tx22;
    logic [PROD_W-1:0] tx67;
    logic              same;
    dir_e              d;
    ax   = dx[GRAD_W-1] ? GRAD_W'(-dx) : GRAD_W'(dx);
    ay   = dy[GRAD_W-1] ? GRAD_W'(-dy) : GRAD_W'(dy);
    ty   = PROD_W'(ay) * PROD_W'(TAN_DEN);
    tx22 = PROD_W'(ax) * PROD_W'(TAN22_NUM);
    tx67 = PROD_W'(ax) * PROD_W'(TAN67_NUM);
    same = (dy != '0) && (dx[GRAD_W-1] == dy[GRAD_W-1]);
    if (dx == '0) begin
      d = DIR_VERT;
    end else if (same) begin
      d = (ty < tx22) ? DIR_HORZ : ((ty < tx67) ? DIR_DIAG_DR : DIR_VERT);
    end else begin
      d = (ty > tx67) ? DIR_VERT : ((ty > tx22) ? DIR_DIAG_DL : DIR_HORZ);
    end
    return d;
  endfunction

endpackage

// ----- hw/rtl/sne_if.sv -----
// Valid/ready channel interfaces: pixel input, result output, register writes.
// Depends on sne_pkg for field widths.
interface sne_pix_if import sne_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             flush;
  modport source (output valid, pixel, flush, input ready);
  modport sink   (input valid, pixel, flush, output ready);
endinterface

interface sne_res_if import sne_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               out_valid;
  logic [CLASS_W-1:0] edge_class;
  logic [DIR_W-1:0]   direction;
  logic [MAG_W-1:0]   magnitude;
  logic               frame_end;
  modport source (output valid, out_valid, edge_class, direction, magnitude, frame_end,
                  input ready);
  modport sink   (input valid, out_valid, edge_class, direction, magnitude, frame_end,
                  output ready);
endinterface

interface sne_cfg_if import sne_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/sne_cfg_regs.sv -----
// Configuration registers: thresholds and clamped frame size.
// Depends on sne_pkg and sne_cfg_if.
module sne_cfg_regs import sne_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sne_cfg_if.sink          cfg_i,
  output logic [THR_W-1:0] high_thr_o,
  output logic [THR_W-1:0] low_thr_o,
  output logic [WW-1:0]    width_o,
  output logic [HW-1:0]    height_o,
  output logic             restart_o
);

  localparam int unsigned W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int unsigned H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

  logic [THR_W-1:0]  high_q, low_q;
  logic [WW-1:0]     width_q, width_d;
  logic [HW-1:0]     height_q, height_d;
  logic [WCFG_W-1:0] wv;
  logic [HCFG_W-1:0] hv;
  logic              wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid;
  assign wv = cfg_i.data[WCFG_W-1:0];
  assign hv = cfg_i.data[HCFG_W-1:0];

  // clamp the size to the supported range at write time
  always_comb begin
    if (int'(wv) < int'(MIN_SIZE)) begin
      width_d = WW'(MIN_SIZE);
    end else if (int'(wv) > int'(MAX_WIDTH)) begin
      width_d = WW'(MAX_WIDTH);
    end else begin
      width_d = WW'(wv);
    end
    if (int'(hv) < int'(MIN_SIZE)) begin
      height_d = HW'(MIN_SIZE);
    end else if (int'(hv) > int'(MAX_HEIGHT)) begin
      height_d = HW'(MAX_HEIGHT);
    end else begin
      height_d = HW'(hv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q   <= THR_W'(HIGH_RESET);
      low_q    <= THR_W'(LOW_RESET);
      width_q  <= WW'(W_RST);
      height_q <= HW'(H_RST);
    end else if (wr) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_HIGH_THR: high_q   <= cfg_i.data[THR_W-1:0];
        CFG_LOW_THR:  low_q    <= cfg_i.data[THR_W-1:0];
        CFG_WIDTH:    width_q  <= width_d;
        CFG_HEIGHT:   height_q <= height_d;
        default:      ;
      endcase
    end
  end

  assign restart_o  = wr && ((cfg_reg_e'(cfg_i.index) == CFG_WIDTH) ||
                             (cfg_reg_e'(cfg_i.index) == CFG_HEIGHT));
  assign high_thr_o = high_q;
  assign low_thr_o  = low_q;
  assign width_o    = width_q;
  assign height_o   = height_q;

endmodule

// ----- hw/rtl/sne_front.sv -----
// Position counters, pixel line memory, 3x3 pixel window and Sobel gradients.
// Depends on sne_pkg.
module sne_front import sne_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int unsigned AW = $clog2(MAX_WIDTH),
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     acc_i,
  input  logic [PIX_W-1:0]         pixel_i,
  input  logic                     flush_i,
  input  logic [WW-1:0]            width_i,
  input  logic [HW-1:0]            height_i,
  input  logic                     restart_i,
  output logic                     s2_valid_o,
  output pos_flags_t               s2_flags_o,
  output logic [AW-1:0]            s2_cc_o,
  output logic signed [GRAD_W-1:0] dx_o,
  output logic signed [GRAD_W-1:0] dy_o
);

  localparam int unsigned RW = $clog2(MAX_HEIGHT + 4);
  localparam int unsigned SW = PIX_W + 2;

  logic [AW-1:0]        col_q;
  logic [RW-1:0]        row_q;
  logic [RW-1:0]        h_x;
  logic                 last_col;
  logic [PIX_W-1:0]     px0;
  logic [AW-1:0]        cc0;
  pos_flags_t           flags0;

  logic [2*PIX_W-1:0]   pix_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]   rd_q;

  logic                 s1_valid_q;
  logic [AW-1:0]        s1_col_q, s1_cc_q;
  logic [PIX_W-1:0]     s1_px_q;
  pos_flags_t           s1_flags_q;

  logic [PIX_W-1:0]     win_q [9];
  logic [PIX_W-1:0]     win_in [3];

  logic                 s2_valid_q;
  logic [AW-1:0]        s2_cc_q;
  pos_flags_t           s2_flags_q;

  logic [SW-1:0]        xp, xn, yp, yn;
  logic signed [SW:0]   dx_full, dy_full;

  assign h_x      = RW'(height_i);
  assign last_col = (WW'(col_q) == (width_i - WW'(1)));
  assign px0      = (!flush_i && (row_q < h_x)) ? pixel_i : '0;
  assign cc0      = (col_q == '0) ? AW'(width_i - WW'(1)) : (col_q - AW'(1));

  // classify the positions that this item touches at each stage
  always_comb begin
    flags0.grad_en   = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
    flags0.grad_int  = (col_q >= AW'(2)) && (row_q >= RW'(2)) && (row_q < h_x);
    flags0.cls_en    = (col_q >= AW'(2)) ? ((row_q >= RW'(2)) && (row_q < h_x + RW'(2)))
                                         : (row_q >= RW'(3));
    flags0.cls_int   = ((col_q >= AW'(3)) && (row_q >= RW'(3)) && (row_q <= h_x)) ||
                       ((col_q == '0) && (row_q >= RW'(4)) && (row_q <= h_x + RW'(1)));
    flags0.frame_end = (col_q == AW'(1)) && (row_q == h_x + RW'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc_i) begin
      if (flags0.frame_end) begin
        col_q <= '0;
        row_q <= '0;
      end else if (last_col) begin
        col_q <= '0;
        row_q <= row_q + RW'(1);
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // line memory: lower half is the older row, upper half the newer row
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      rd_q <= pix_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      pix_mem[s1_col_q] <= {s1_px_q, rd_q[2*PIX_W-1:PIX_W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_col_q   <= col_q;
      s1_cc_q    <= cc0;
      s1_px_q    <= px0;
      s1_flags_q <= flags0;
    end
    if (s1_valid_q) begin
      s2_cc_q    <= s1_cc_q;
      s2_flags_q <= s1_flags_q;
    end
  end

  assign win_in[0] = rd_q[PIX_W-1:0];
  assign win_in[1] = rd_q[2*PIX_W-1:PIX_W];
  assign win_in[2] = s1_px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
        win_q[r*3+2] <= win_in[r];
      end
    end
  end

  // Sobel on the window as it stands after this item's shift
  assign xp = SW'(win_q[2]) + SW'({win_q[5], 1'b0}) + SW'(win_q[8]);
  assign xn = SW'(win_q[0]) + SW'({win_q[3], 1'b0}) + SW'(win_q[6]);
  assign yp = SW'(win_q[6]) + SW'({win_q[7], 1'b0}) + SW'(win_q[8]);
  assign yn = SW'(win_q[0]) + SW'({win_q[1], 1'b0}) + SW'(win_q[2]);
  assign dx_full = $signed({1'b0, xp}) - $signed({1'b0, xn});
  assign dy_full = $signed({1'b0, yp}) - $signed({1'b0, yn});

  assign dx_o       = s2_flags_q.grad_int ? GRAD_W'(dx_full) : '0;
  assign dy_o       = s2_flags_q.grad_int ? GRAD_W'(dy_full) : '0;
  assign s2_valid_o = s2_valid_q;
  assign s2_flags_o = s2_flags_q;
  assign s2_cc_o    = s2_cc_q;

  a_restart_at_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && flags0.frame_end) |=> ((col_q == '0) && (row_q == '0)))
    else $error("counters not cleared after the frame's last position");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!restart_i) |-> (WW'(col_q) < width_i || $past(restart_i)))
    else $error("column counter beyond row width");

endmodule

// ----- hw/rtl/sne_nms.sv -----
// Magnitude/gradient line memory, 3x3 magnitude window, suppression and thresholds.
// Depends on sne_pkg.
module sne_nms import sne_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s2_valid_i,
  input  pos_flags_t               s2_flags_i,
  input  logic [AW-1:0]            s2_cc_i,
  input  logic signed [GRAD_W-1:0] dx_i,
  input  logic signed [GRAD_W-1:0] dy_i,
  input  logic [THR_W-1:0]         high_thr_i,
  input  logic [THR_W-1:0]         low_thr_i,
  output logic                     push_o,
  output result_t                  result_o
);

  localparam int unsigned MW = 2 * MAG_W + 2 * GRAD_W;

  // word: {dy, dx, newer magnitude row, older magnitude row}
  logic [MW-1:0]              grad_mem [MAX_WIDTH];
  logic [MW-1:0]              rd_q;

  logic                       s3_valid_q;
  pos_flags_t                 s3_flags_q;
  logic [AW-1:0]              s3_cc_q;
  logic signed [GRAD_W-1:0]   s3_dx_q, s3_dy_q;
  logic [GRAD_W-1:0]          ax, ay;
  logic [MAG_W-1:0]           mag;
  logic [MAG_W-1:0]           mwin_q [9];
  logic [MAG_W-1:0]           mwin_in [3];
  logic signed [GRAD_W-1:0]   held_dx_q, held_dy_q;

  logic                       s4_valid_q;
  pos_flags_t                 s4_flags_q;
  logic signed [GRAD_W-1:0]   t_dx_q, t_dy_q;

  dir_e                       dir;
  logic [MAG_W-1:0]           na, nb, mc;
  result_t                    res;

  always_ff @(posedge clk_i) begin
    if (s2_valid_i && s2_flags_i.grad_en) begin
      rd_q <= grad_mem[s2_cc_i];
    end
  end

  // consecutive items never share an entry, so write-back needs no forwarding
  always_ff @(posedge clk_i) begin
    if (s3_valid_q && s3_flags_q.grad_en) begin
      grad_mem[s3_cc_q] <= {s3_dy_q, s3_dx_q, mag, rd_q[2*MAG_W-1:MAG_W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_i;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_i) begin
      s3_flags_q <= s2_flags_i;
      s3_cc_q    <= s2_cc_i;
      s3_dx_q    <= dx_i;
      s3_dy_q    <= dy_i;
    end
    if (s3_valid_q) begin
      s4_flags_q <= s3_flags_q;
      t_dx_q     <= held_dx_q;
      t_dy_q     <= held_dy_q;
    end
  end

  assign ax  = s3_dx_q[GRAD_W-1] ? GRAD_W'(-s3_dx_q) : GRAD_W'(s3_dx_q);
  assign ay  = s3_dy_q[GRAD_W-1] ? GRAD_W'(-s3_dy_q) : GRAD_W'(s3_dy_q);
  assign mag = MAG_W'(ax) + MAG_W'(ay);

  assign mwin_in[0] = s3_flags_q.grad_en ? rd_q[MAG_W-1:0] : '0;
  assign mwin_in[1] = s3_flags_q.grad_en ? rd_q[2*MAG_W-1:MAG_W] : '0;
  assign mwin_in[2] = s3_flags_q.grad_en ? mag : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        mwin_q[i] <= '0;
      end
      held_dx_q <= '0;
      held_dy_q <= '0;
    end else if (s3_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        mwin_q[r*3]   <= mwin_q[r*3+1];
        mwin_q[r*3+1] <= mwin_q[r*3+2];
        mwin_q[r*3+2] <= mwin_in[r];
      end
      if (s3_flags_q.grad_en) begin
        held_dx_q <= rd_q[2*MAG_W+GRAD_W-1:2*MAG_W];
        held_dy_q <= rd_q[MW-1:2*MAG_W+GRAD_W];
      end else begin
        held_dx_q <= '0;
        held_dy_q <= '0;
      end
    end
  end

  assign dir = quantize(t_dx_q, t_dy_q);
  assign mc  = mwin_q[4];

  always_comb begin
    case (dir)
      DIR_HORZ:    begin na = mwin_q[3]; nb = mwin_q[5]; end
      DIR_DIAG_DR: begin na = mwin_q[0]; nb = mwin_q[8]; end
      DIR_VERT:    begin na = mwin_q[1]; nb = mwin_q[7]; end
      DIR_DIAG_DL: begin na = mwin_q[2]; nb = mwin_q[6]; end
      default:     begin na = mwin_q[1]; nb = mwin_q[7]; end
    endcase
  end

  always_comb begin
    res = '0;
    if (s4_flags_q.cls_en) begin
      res.out_valid = 1'b1;
      res.frame_end = s4_flags_q.frame_end;
      if (s4_flags_q.cls_int) begin
        res.direction = dir;
        res.magnitude = mc;
        if ((mc > low_thr_i) && (mc >= na) && (mc >= nb)) begin
          res.edge_class = (mc > high_thr_i) ? CLASS_STRONG : CLASS_WEAK;
        end else begin
          res.edge_class = CLASS_BG;
        end
      end else begin
        res.direction = DIR_VERT;
      end
    end
  end

  assign push_o   = s4_valid_q;
  assign result_o = res;

  a_border_is_background: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_valid_q && !s4_flags_q.cls_int) |-> (res.edge_class == CLASS_BG && res.magnitude == '0))
    else $error("border pixel classified as edge");

endmodule

// ----- hw/rtl/sne_out_fifo.sv -----
// Result queue that parts the pipeline from the downstream ready.
// Depends on sne_pkg and sne_res_if.
module sne_out_fifo import sne_pkg::*; #(
  parameter int unsigned DEPTH = OUT_DEPTH,
  localparam int unsigned PW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  result_t  data_i,
  sne_res_if.source res_o
);

  result_t       buf_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] count_q;
  logic          pop;
  result_t       head;

  assign pop  = res_o.valid && res_o.ready;
  assign head = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      count_q <= count_q + CW'(push_i) - CW'(pop);
    end
  end

  assign res_o.valid      = (count_q != '0);
  assign res_o.out_valid  = head.out_valid;
  assign res_o.edge_class = head.edge_class;
  assign res_o.direction  = head.direction;
  assign res_o.magnitude  = head.magnitude;
  assign res_o.frame_end  = head.frame_end;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < CW'(DEPTH)))
    else $error("result pushed into a full queue");

endmodule

// ----- hw/rtl/sobel_nms_edge_classifier_top.sv -----
// Top level of the Sobel/NMS edge classifier: ports, occupancy-based input ready.
// Depends on sne_pkg, sne_if, sne_cfg_regs, sne_front, sne_nms and sne_out_fifo.
//
// Usage
// - px_i carries one gray pixel per beat in raster order, or a flush beat.
//   Every input beat yields exactly one result beat on res_o, describing the
//   pixel 2*width+2 positions earlier; send 2*width+2 flush beats after each
//   frame to push out its last results. out_valid is low while the window
//   fills, frame_end marks the frame's last pixel, after which a new frame
//   starts.
// - cfg_i writes thresholds and the frame size (index as in cfg_reg_e); it
//   is always ready. Write only while idle. A size write restarts the frame.
// - Throughput: one beat per clock while px_i.ready is high. The pipeline is
//   one pixel-memory read, one Sobel stage, one gradient-memory read, the
//   magnitude read-modify-write and the suppression stage.
// - Stall: the results sit in an 8-entry queue; px_i.ready drops only once
//   eight beats are in flight or queued, never combinationally on res_o.ready.
// - Reset: counters, windows and thresholds return to defaults. The line
//   memories are not cleared; their stale entries only feed border positions.
module sobel_nms_edge_classifier_top import sne_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sne_pix_if.sink   px_i,
  sne_res_if.source res_o,
  sne_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned OW = $clog2(OUT_DEPTH + 1);

  logic [THR_W-1:0]         high_thr, low_thr;
  logic [WW-1:0]            width;
  logic [HW-1:0]            height;
  logic                     restart;
  logic                     acc, pop;
  logic [OW-1:0]            occ_q, occ_d;
  logic                     s2_valid;
  pos_flags_t               s2_flags;
  logic [AW-1:0]            s2_cc;
  logic signed [GRAD_W-1:0] dx, dy;
  logic                     push;
  result_t                  result;

  sne_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .high_thr_o (high_thr),
    .low_thr_o  (low_thr),
    .width_o    (width),
    .height_o   (height),
    .restart_o  (restart)
  );

  // hold off input once every queue slot is spoken for
  assign px_i.ready = (occ_q < OW'(OUT_DEPTH));
  assign acc        = px_i.valid && px_i.ready;
  assign pop        = res_o.valid && res_o.ready;
  assign occ_d      = occ_q + OW'(acc) - OW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  sne_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .pixel_i    (px_i.pixel),
    .flush_i    (px_i.flush),
    .width_i    (width),
    .height_i   (height),
    .restart_i  (restart),
    .s2_valid_o (s2_valid),
    .s2_flags_o (s2_flags),
    .s2_cc_o    (s2_cc),
    .dx_o       (dx),
    .dy_o       (dy)
  );

  sne_nms #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_nms (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s2_valid_i (s2_valid),
    .s2_flags_i (s2_flags),
    .s2_cc_i    (s2_cc),
    .dx_i       (dx),
    .dy_i       (dy),
    .high_thr_i (high_thr),
    .low_thr_i  (low_thr),
    .push_o     (push),
    .result_o   (result)
  );

  sne_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (result),
    .res_o  (res_o)
  );

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(OUT_DEPTH))
    else $error("more beats in flight than queue slots");

  a_empty_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> !res_o.valid)
    else $error("result offered with nothing in flight");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the Sobel/NMS edge classifier: random framed pixel streams,
// a scoreboard class with a bit-true predictor, random idling on both channels.
// Depends on sne_pkg, the sne_if interfaces and sobel_nms_edge_classifier_top.
`timescale 1ns / 1ps

module tb_top;
  import sne_pkg::*;

  localparam int MW = MAX_WIDTH_DEF;
  localparam int MH = MAX_HEIGHT_DEF;

  // Scoreboard: own copy of the classifier state, one expected beat per accepted pixel
  class edge_scoreboard;
    int unsigned high_thr, low_thr, width_reg, height_reg;
    int          pix_rows[2*MW];
    int          mag_rows[2*MW];
    int          row_dx[MW];
    int          row_dy[MW];
    int          win[18];
    int          col_pos, row_pos, held_dx, held_dy;
    result_t     want_q[$];
    int          errors;

    function new();
      high_thr   = HIGH_RESET;
      low_thr    = LOW_RESET;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (pix_rows[i]) pix_rows[i] = 0;
      foreach (mag_rows[i]) mag_rows[i] = 0;
      foreach (row_dx[i]) row_dx[i] = 0;
      foreach (row_dy[i]) row_dy[i] = 0;
      foreach (win[i]) win[i] = 0;
      col_pos = 0;
      row_pos = 0;
      held_dx = 0;
      held_dy = 0;
      errors  = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function void write_reg(cfg_reg_e idx, int unsigned val);
      case (idx)
        CFG_HIGH_THR: high_thr = val & 'h7FF;
        CFG_LOW_THR:  low_thr  = val & 'h7FF;
        CFG_WIDTH: begin
          width_reg = val & 'h7FF;
          col_pos   = 0;
          row_pos   = 0;
        end
        CFG_HEIGHT: begin
          height_reg = val & 'h1FFF;
          col_pos    = 0;
          row_pos    = 0;
        end
        default: ;
      endcase
    endfunction

    function void shift_win(int base, int a, int b, int c);
      int nv[3];
      nv[0] = a; nv[1] = b; nv[2] = c;
      for (int r = 0; r < 3; r++) begin
        win[base+r*3]   = win[base+r*3+1];
        win[base+r*3+1] = win[base+r*3+2];
        win[base+r*3+2] = nv[r];
      end
    endfunction

    function dir_e bin_direction(int dx, int dy);
      int ax, ay;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (dx == 0) return DIR_VERT;
      if (dy != 0 && ((dx > 0) == (dy > 0))) begin
        if (TAN_DEN*ay < TAN22_NUM*ax) return DIR_HORZ;
        if (TAN_DEN*ay < TAN67_NUM*ax) return DIR_DIAG_DR;
        return DIR_VERT;
      end
      if (TAN_DEN*ay > TAN67_NUM*ax) return DIR_VERT;
      if (TAN_DEN*ay > TAN22_NUM*ax) return DIR_DIAG_DL;
      return DIR_HORZ;
    endfunction

    function bit is_inner(int r, int c, int w, int h);
      return r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix, logic fl);
      int      w, h, total, c, n, v, older, newer, tdx, tdy;
      int      m1, rc, cc, dx, dy, mg, m2, tr, tc, m, a, b;
      dir_e    d;
      result_t want;
      w = width_reg < MIN_SIZE ? MIN_SIZE : (width_reg > MW ? MW : width_reg);
      h = height_reg < MIN_SIZE ? MIN_SIZE : (height_reg > MH ? MH : height_reg);
      total = w * h;
      c = col_pos < w ? col_pos : w - 1;
      n = row_pos * w + c;
      tdx = held_dx;
      tdy = held_dy;
      want = '0;
      v = (!fl && n < total) ? int'(pix) : 0;

      older = pix_rows[c];
      newer = pix_rows[MW+c];
      shift_win(0, older, newer, v);
      pix_rows[c]    = newer;
      pix_rows[MW+c] = v;

      if (n >= w + 1) begin
        m1 = n - w - 1;
        rc = m1 / w;
        cc = m1 % w;
        dx = 0;
        dy = 0;
        if (is_inner(rc, cc, w, h)) begin
          dx = win[2] + 2*win[5] + win[8] - win[0] - 2*win[3] - win[6];
          dy = win[6] + 2*win[7] + win[8] - win[0] - 2*win[1] - win[2];
        end
        mg = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
        held_dx = row_dx[cc];
        held_dy = row_dy[cc];
        row_dx[cc] = dx;
        row_dy[cc] = dy;
        older = mag_rows[cc];
        newer = mag_rows[MW+cc];
        shift_win(9, older, newer, mg);
        mag_rows[cc]    = newer;
        mag_rows[MW+cc] = mg;
      end else begin
        held_dx = 0;
        held_dy = 0;
        shift_win(9, 0, 0, 0);
      end

      if (n >= 2*w + 2 && n - 2*w - 2 < total) begin
        m2 = n - 2*w - 2;
        tr = m2 / w;
        tc = m2 % w;
        want.out_valid = 1'b1;
        want.frame_end = (m2 == total - 1);
        if (is_inner(tr, tc, w, h)) begin
          m = win[13];
          d = bin_direction(tdx, tdy);
          want.direction = d;
          want.magnitude = MAG_W'(m);
          case (d)
            DIR_HORZ:    begin a = win[12]; b = win[14]; end
            DIR_DIAG_DR: begin a = win[9];  b = win[17]; end
            DIR_VERT:    begin a = win[10]; b = win[16]; end
            default:     begin a = win[11]; b = win[15]; end
          endcase
          if (m > int'(low_thr) && m >= a && m >= b)
            want.edge_class = (m > int'(high_thr)) ? CLASS_STRONG : CLASS_WEAK;
        end else begin
          want.direction = DIR_VERT;
        end
      end

      if (n + 1 >= total + 2*w + 2) begin
        col_pos = 0;
        row_pos = 0;
      end else if (c + 1 >= w) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos = c + 1;
      end
      want_q.push_back(want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (want_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = want_q.pop_front();
      if (got.out_valid !== want.out_valid) begin
        $error("out_valid: expected %0d, got %0d", want.out_valid, got.out_valid);
        errors++;
      end
      if (got.edge_class !== want.edge_class) begin
        $error("edge_class: expected %0d, got %0d", want.edge_class, got.edge_class);
        errors++;
      end
      if (got.direction !== want.direction) begin
        $error("direction: expected %0d, got %0d", want.direction, got.direction);
        errors++;
      end
      if (got.magnitude !== want.magnitude) begin
        $error("magnitude: expected %0d, got %0d", want.magnitude, got.magnitude);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  sne_pix_if px();
  sne_res_if res();
  sne_cfg_if cfg();

  sobel_nms_edge_classifier_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .px_i   (px),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  edge_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  // calm: both sides run without idling for the current stretch
  bit calm;
  int sink_hold;
  int sink_draw;
  int pix_count;
  bit paused_once;

  // image content knobs for the current frame
  int shape, ka, kb, kc, lo_val, hi_val;

  // Note every accepted pixel and register beat in the predictor
  always @(posedge clk_i) begin
    if (rst_ni && px.valid && px.ready) sb.note_pixel(px.pixel, px.flush);
    if (rst_ni && cfg.valid && cfg.ready) sb.write_reg(cfg_reg_e'(cfg.index), cfg.data);
  end

  // Result side: check each beat, then draw how long to hold ready low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
      sink_hold <= 0;
    end else begin
      if (res.valid && res.ready) begin
        sb.check_result({res.out_valid, res.edge_class, res.direction, res.magnitude,
                         res.frame_end});
        sink_draw = calm ? 0 : $urandom_range(0, 4);
        res.ready <= (sink_draw == 0);
        sink_hold <= (sink_draw == 0) ? 0 : sink_draw - 1;
      end else if (sink_hold > 0) begin
        res.ready <= 1'b0;
        sink_hold <= sink_hold - 1;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Send one pixel beat after a random gap; leave valid high for the next call
  task automatic push_pixel(logic [PIX_W-1:0] pix, logic fl);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      px.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    px.valid <= 1'b1;
    px.pixel <= pix;
    px.flush <= fl;
    do @(posedge clk_i); while (!px.ready);
    pix_count++;
  endtask

  // Hold the pixel side until every expected result has arrived, plus the pipeline depth
  task automatic drain();
    px.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= CFG_DATA_W'(val);
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic setup(int unsigned hi, int unsigned lo, int unsigned w, int unsigned h);
    drain();
    write_reg(CFG_HIGH_THR, hi);
    write_reg(CFG_LOW_THR, lo);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  function automatic logic [PIX_W-1:0] pixel_at(int r, int c);
    int v;
    case (shape)
      0: v = $urandom_range(0, 255);
      1: v = ((ka*r + kb*c > kc) ? hi_val : lo_val) + $urandom_range(0, 7) - 4;
      2: v = $urandom_range(0, 1) ? 255 : 0;
      default: v = (ka*r + kb*c + kc) & 'hFF;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  // One frame of pixels, then the flush beats that push out its tail.
  // stop_at >= 0 abandons the frame after that many pixels.
  task automatic run_frame(int w, int h, int stop_at);
    int k;
    k = 0;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (stop_at >= 0 && k == stop_at) return;
        // once, pause the sender mid-frame until everything is out
        if (!paused_once && r == h/2 && c == w/2 && h > 3) begin
          paused_once = 1'b1;
          px.valid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk_i);
        end
        push_pixel(pixel_at(r, c), $urandom_range(0, 99) == 0);
        k++;
      end
    end
    // flush phase; now and then a stray pixel beat, which must be ignored
    for (int i = 0; i < 2*w + 2; i++) begin
      if ($urandom_range(0, 19) == 0) push_pixel(PIX_W'($urandom), 1'b0);
      else push_pixel(PIX_W'($urandom), 1'b1);
    end
  endtask

  task automatic pick_shape();
    shape  = $urandom_range(0, 3);
    ka     = $urandom_range(0, 60) - 30;
    kb     = $urandom_range(0, 60) - 30;
    kc     = $urandom_range(0, 100) - 50;
    lo_val = $urandom_range(0, 120);
    hi_val = $urandom_range(130, 255);
  endtask

  initial begin
    int w, h, hi, lo;
    rst_ni      = 1'b0;
    px.valid    <= 1'b0;
    px.pixel    <= '0;
    px.flush    <= 1'b0;
    cfg.valid   <= 1'b0;
    cfg.index   <= CFG_HIGH_THR;
    cfg.data    <= '0;
    calm        = 1'b0;
    pix_count   = 0;
    paused_once = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: smallest frame, full-scale checkerboard, flush inside the frame,
    // a stray pixel in the flush phase
    setup(HIGH_RESET, LOW_RESET, 3, 3);
    push_pixel(8'd0, 1'b0);   push_pixel(8'd255, 1'b0); push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0); push_pixel(8'd0, 1'b1);   push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b0);   push_pixel(8'd255, 1'b0); push_pixel(8'd0, 1'b0);
    push_pixel(8'd77, 1'b0);
    repeat (7) push_pixel(8'd255, 1'b1);

    // Threshold extremes and clamped sizes
    shape = 2;
    setup(0, 0, 0, 1);
    run_frame(3, 3, -1);
    setup(2047, 2047, 4, 4);
    run_frame(4, 4, -1);
    setup(2047, 0, 5, 4);
    run_frame(5, 4, -1);

    // Random frames, mostly small
    pix_count = 0;
    while (pix_count < 800) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      hi = $urandom_range(0, 600);
      lo = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) : $urandom_range(0, hi);
      if ($urandom_range(0, 9) == 0) hi = 2047;
      calm = ($urandom_range(0, 3) == 0);
      pick_shape();
      setup(hi, lo, w, h);
      // now and then abandon a frame; the next size write restarts it
      run_frame(w, h, $urandom_range(0, 9) == 0 ? $urandom_range(0, w*h - 1) : -1);
    end

    // Widest frame and tallest frame, both written past the limit; start each
    // and abandon it partway
    calm = 1'b0;
    pick_shape();
    setup(150, 60, 2047, 3);
    run_frame(MW, 3, 400);
    pick_shape();
    setup(100, 40, 3, 8191);
    run_frame(3, MH, 300);

    px.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
